FILE: rtl/core/sppt_pkg.sv
package sppt_pkg;

  // Byte classification codes
  localparam logic [3:0] KIND_TYPE     = 4'd0;
  localparam logic [3:0] KIND_LENGTH   = 4'd1;
  localparam logic [3:0] KIND_ID_HIGH  = 4'd2;
  localparam logic [3:0] KIND_ID_LOW   = 4'd3;
  localparam logic [3:0] KIND_TOPIC_LEN = 4'd4;
  localparam logic [3:0] KIND_PATH     = 4'd5;
  localparam logic [3:0] KIND_SEP      = 4'd6;
  localparam logic [3:0] KIND_WILD     = 4'd7;
  localparam logic [3:0] KIND_QOS      = 4'd8;

  // Wildcard codes
  localparam logic [1:0] WILD_NONE  = 2'd0;
  localparam logic [1:0] WILD_HASH  = 2'd1;
  localparam logic [1:0] WILD_PLUS  = 2'd2;
  localparam logic [1:0] WILD_DOLLAR = 2'd3;

  // Topic characters of interest
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;

  // Packet type sits in the upper nibble of the fixed header
  localparam int unsigned TYPE_SHIFT = 4;

  localparam int unsigned TDATA_W = 56;
  localparam int unsigned TUSER_W = 4;

  // One result beat
  typedef struct packed {
    logic [7:0]  qos_value;
    logic        final_segment;
    logic        has_child;
    logic [1:0]  wildcard_seen;
    logic [7:0]  byte_echo;
    logic [7:0]  segment_number;
    logic [7:0]  topic_number;
    logic [15:0] packet_ident;
    logic [3:0]  packet_kind;
    logic [3:0]  byte_kind;
    logic        packet_end;
  } sppt_result_t;

endpackage

FILE: rtl/core/subscribe_packet_topic_parser_unit.sv
// Subscribe packet topic parser.
// Input channel in_*: one packet byte per beat in in_tdata; in_tuser is high on
// the fixed-header byte that opens a packet. Output channel out_*: one
// classification beat per byte, except bytes that arrive with no packet open,
// which are dropped without a result. out_tuser carries the byte kind and
// out_tlast marks the QoS byte that completes the packet.
// Each accepted byte waits in the input register and is then parsed into the
// result buffer, whose output slot drives out_tvalid and the result fields.
// Throughput: one byte per cycle while the result buffer has room; the next
// parse state is computed combinationally from each byte.
// Reset (rst_n low, synchronous) closes any open packet, clears all counters
// and empties both stages. When the receiver stalls, a two-entry result
// buffer absorbs the beat in flight; in_tready drops only once that buffer
// and the input register are both full, and no beat is lost or repeated.
module subscribe_packet_topic_parser_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] data_byte
  input  logic                         in_tuser,   // [0] packet_start
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [3:0] packet_kind, [19:4] packet_ident, [27:20] topic_number,
  // [35:28] segment_number, [43:36] byte_echo, [45:44] wildcard_seen,
  // [46] has_child, [47] final_segment, [55:48] qos_value
  output logic [sppt_pkg::TDATA_W-1:0] out_tdata,
  output logic [sppt_pkg::TUSER_W-1:0] out_tuser,  // [3:0] byte_kind
  output logic                         out_tlast   // packet_end
);
  import sppt_pkg::*;

  logic         in_v_r;
  logic [7:0]   in_byte_r;
  logic         in_start_r;
  logic         buf_ready;
  logic         advance;
  logic         res_valid;
  sppt_result_t res;
  sppt_result_t out_res;
  logic         out_valid;

  // The input register steps whenever the result buffer can take a beat
  assign advance   = in_v_r && buf_ready;
  assign in_tready = !in_v_r || buf_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  sppt_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .data_byte    (in_byte_r),
    .packet_start (in_start_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  sppt_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (advance && res_valid),
    .push_ready (buf_ready),
    .push_data  (res),
    .pop_valid  (out_valid),
    .pop_ready  (out_tready),
    .pop_data   (out_res)
  );

  // Pack the result beat
  assign out_tvalid = out_valid;
  assign out_tuser  = out_res.byte_kind;
  assign out_tlast  = out_res.packet_end;
  assign out_tdata  = {out_res.qos_value, out_res.final_segment, out_res.has_child,
                       out_res.wildcard_seen, out_res.byte_echo, out_res.segment_number,
                       out_res.topic_number, out_res.packet_ident, out_res.packet_kind};

endmodule

FILE: rtl/core/sppt_parse.sv
module sppt_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  packet_start,
  output logic                  res_valid,
  output sppt_pkg::sppt_result_t res
);
  import sppt_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEN, PH_IDHI, PH_IDLO, PH_TLHI, PH_TLLO, PH_BODY, PH_QOS
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  ptype_r, ptype_nxt;
  logic [7:0]  rem_len_r, rem_len_nxt;
  logic [7:0]  consumed_r, consumed_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [15:0] tcount_r, tcount_nxt;
  logic [7:0]  topic_idx_r, topic_idx_nxt;
  logic [7:0]  seg_idx_r, seg_idx_nxt;
  logic        seg_nonempty_r, seg_nonempty_nxt;
  logic [1:0]  wild_r, wild_nxt;
  logic        child_r, child_nxt;

  logic [3:0]  kind;
  logic        fin;
  logic [7:0]  qos;
  logic        pend;

  // Per-byte state update and classification
  always_comb begin
    phase_nxt        = phase_r;
    ptype_nxt        = ptype_r;
    rem_len_nxt      = rem_len_r;
    consumed_nxt     = consumed_r;
    ident_nxt        = ident_r;
    tlen_nxt         = tlen_r;
    tcount_nxt       = tcount_r;
    topic_idx_nxt    = topic_idx_r;
    seg_idx_nxt      = seg_idx_r;
    seg_nonempty_nxt = seg_nonempty_r;
    wild_nxt         = wild_r;
    child_nxt        = child_r;
    kind             = KIND_TYPE;
    fin              = 1'b0;
    qos              = 8'd0;
    pend             = 1'b0;
    res_valid        = 1'b0;

    if (packet_start) begin
      res_valid        = 1'b1;
      ptype_nxt        = data_byte[TYPE_SHIFT +: 4];
      rem_len_nxt      = 8'd0;
      consumed_nxt     = 8'd0;
      ident_nxt        = 16'd0;
      topic_idx_nxt    = 8'd0;
      tlen_nxt         = 16'd0;
      tcount_nxt       = 16'd0;
      seg_idx_nxt      = 8'd0;
      seg_nonempty_nxt = 1'b0;
      wild_nxt         = WILD_NONE;
      child_nxt        = 1'b0;
      phase_nxt        = PH_LEN;
    end else if (phase_r != PH_IDLE) begin
      res_valid = 1'b1;
      if (phase_r != PH_LEN && consumed_r != 8'hFF) begin
        consumed_nxt = consumed_r + 8'd1;
      end
      case (phase_r)
        PH_LEN: begin
          rem_len_nxt  = data_byte;
          consumed_nxt = 8'd0;
          phase_nxt    = PH_IDHI;
          kind         = KIND_LENGTH;
        end
        PH_IDHI: begin
          ident_nxt = {data_byte, 8'd0};
          phase_nxt = PH_IDLO;
          kind      = KIND_ID_HIGH;
        end
        PH_IDLO: begin
          ident_nxt = {ident_r[15:8], data_byte};
          phase_nxt = PH_TLHI;
          kind      = KIND_ID_LOW;
        end
        PH_TLHI: begin
          tlen_nxt         = {data_byte, 8'd0};
          tcount_nxt       = 16'd0;
          seg_idx_nxt      = 8'd0;
          seg_nonempty_nxt = 1'b0;
          wild_nxt         = WILD_NONE;
          child_nxt        = 1'b0;
          phase_nxt        = PH_TLLO;
          kind             = KIND_TOPIC_LEN;
        end
        PH_TLLO: begin
          tlen_nxt   = {tlen_r[15:8], data_byte};
          tcount_nxt = 16'd0;
          phase_nxt  = ({tlen_r[15:8], data_byte} == 16'd0) ? PH_QOS : PH_BODY;
          kind       = KIND_TOPIC_LEN;
        end
        PH_BODY: begin
          if (data_byte == CHAR_HASH) begin
            wild_nxt = WILD_HASH;
            kind     = KIND_WILD;
          end else if (data_byte == CHAR_PLUS) begin
            wild_nxt = WILD_PLUS;
            kind     = KIND_WILD;
          end else if (data_byte == CHAR_DOLLAR) begin
            wild_nxt = WILD_DOLLAR;
            kind     = KIND_WILD;
          end else if (data_byte == CHAR_SLASH) begin
            child_nxt        = 1'b1;
            seg_idx_nxt      = (seg_idx_r == 8'hFF) ? seg_idx_r : seg_idx_r + 8'd1;
            seg_nonempty_nxt = 1'b0;
            kind             = KIND_SEP;
          end else begin
            seg_nonempty_nxt = 1'b1;
            kind             = KIND_PATH;
          end
          tcount_nxt = tcount_r + 16'd1;
          if (tcount_nxt >= tlen_r) begin
            phase_nxt = PH_QOS;
          end
        end
        PH_QOS: begin
          kind = KIND_QOS;
          fin  = seg_nonempty_r;
          qos  = data_byte;
          if (consumed_nxt >= rem_len_r) begin
            pend      = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt     = PH_TLHI;
            topic_idx_nxt = (topic_idx_r == 8'hFF) ? topic_idx_r : topic_idx_r + 8'd1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Result fields: topic index before its advance, everything else after
  always_comb begin
    res.byte_kind      = kind;
    res.packet_kind    = ptype_nxt;
    res.packet_ident   = ident_nxt;
    res.topic_number   = packet_start ? 8'd0 : topic_idx_r;
    res.segment_number = seg_idx_nxt;
    res.byte_echo      = data_byte;
    res.wildcard_seen  = wild_nxt;
    res.has_child      = child_nxt;
    res.final_segment  = fin;
    res.qos_value      = qos;
    res.packet_end     = pend;
  end

  // Hold parser state, advance on each stepped byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      ptype_r        <= 4'd0;
      rem_len_r      <= 8'd0;
      consumed_r     <= 8'd0;
      ident_r        <= 16'd0;
      tlen_r         <= 16'd0;
      tcount_r       <= 16'd0;
      topic_idx_r    <= 8'd0;
      seg_idx_r      <= 8'd0;
      seg_nonempty_r <= 1'b0;
      wild_r         <= WILD_NONE;
      child_r        <= 1'b0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      ptype_r        <= ptype_nxt;
      rem_len_r      <= rem_len_nxt;
      consumed_r     <= consumed_nxt;
      ident_r        <= ident_nxt;
      tlen_r         <= tlen_nxt;
      tcount_r       <= tcount_nxt;
      topic_idx_r    <= topic_idx_nxt;
      seg_idx_r      <= seg_idx_nxt;
      seg_nonempty_r <= seg_nonempty_nxt;
      wild_r         <= wild_nxt;
      child_r        <= child_nxt;
    end
  end

endmodule

FILE: rtl/core/sppt_out_buf.sv
module sppt_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  sppt_pkg::sppt_result_t push_data,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output sppt_pkg::sppt_result_t pop_data
);
  import sppt_pkg::*;

  logic         main_v_r, main_v_nxt;
  logic         skid_v_r, skid_v_nxt;
  sppt_result_t main_r;
  sppt_result_t skid_r;
  logic         push;
  logic         main_free;

  assign push_ready = !skid_v_r;
  assign push       = push_valid && push_ready;
  assign main_free  = !main_v_r || pop_ready;
  assign pop_valid  = main_v_r;
  assign pop_data   = main_r;

  // Valid flags of the output and skid slots
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (main_free) begin
      main_v_nxt = skid_v_r || push;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Move payload: skid drains first, otherwise take the new beat
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule
